// File: rtl/suq_pkg.sv
// Shared types, constants and helpers for the sphere union query block.
// No dependencies; every other file of the block except suq_ram imports this package.
`timescale 1ns / 1ps

package suq_pkg;

	localparam int SUQ_MAX_SPHERES = 64;
	localparam int SUQ_NUM_DIMS    = 3;

	localparam int COORD_W  = 32;
	localparam int RAD_W    = 31;
	localparam int SQ_W     = 66;   // sum of three squared 32-bit magnitudes
	localparam int RADIC_W  = 72;   // radicand padded to an even bit count
	localparam int ROOT_W   = 36;
	localparam int SREM_W   = 38;
	localparam int NUM_W    = 64;
	localparam int STEP_W   = 7;
	localparam int SQRT_STEPS = ROOT_W;
	localparam int DIV_STEPS  = NUM_W;
	localparam int ENTRY_W  = 3 * COORD_W + RAD_W;

	localparam logic signed [SQ_W-1:0] SAT_HI = 66'sd2147483647;
	localparam logic signed [SQ_W-1:0] SAT_LO = -66'sd2147483648;

	typedef enum logic [1:0] {
		KIND_CLEAR = 2'd0,
		KIND_ADD   = 2'd1,
		KIND_QUERY = 2'd2,
		KIND_NOP   = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE, S_EXEC, S_RD, S_LD, S_SQ, S_SI, S_SQRT, S_EVAL,
		S_BRD, S_BLD, S_PZ, S_DI, S_DIV, S_DF, S_FIN
	} state_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic accept;
		logic exec;
		logic load_cur;
		logic sq_axis;
		logic sqrt_init;
		logic sqrt_step;
		logic eval;
		logic rd_best;
		logic load_best;
		logic proj_zero;
		logic div_init;
		logic div_step;
		logic div_fin;
		logic out_load;
	} cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		kind_t kind;
		logic  empty;
		logic  last_axis;
		logic  last_idx;
		logic  sqrt_last;
		logic  div_last;
		logic  dist_zero;
	} sts_t;

	function automatic logic signed [COORD_W-1:0] sat32(input logic signed [SQ_W-1:0] v);
		logic signed [COORD_W-1:0] r;
		if (v > SAT_HI)
			r = 32'sh7fffffff;
		else if (v < SAT_LO)
			r = 32'sh80000000;
		else
			r = v[COORD_W-1:0];
		return r;
	endfunction

endpackage

// File: rtl/suq_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module suq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    addr,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write the addressed entry when enabled, and read its old contents every cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata_q <= mem[addr];
	end

	assign rdata = rdata_q;

endmodule

// File: rtl/suq_ctrl.sv
// Controller state machine: sequences clear, add, query and no-op items.
// Depends on suq_pkg; drives the command struct of suq_dp.
`timescale 1ns / 1ps

module suq_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	output logic          out_valid,
	input  logic          out_stall,
	input  suq_pkg::sts_t sts,
	output suq_pkg::cmd_t cmd
);
	import suq_pkg::*;

	state_t state_q, state_n;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || !out_stall;

	// next state
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			S_IDLE: if (in_valid) state_n = S_EXEC;
			S_EXEC: begin
				if (sts.kind == KIND_QUERY && !sts.empty)
					state_n = S_LD;
				else
					state_n = S_FIN;
			end
			S_RD:   state_n = S_LD;
			S_LD:   state_n = S_SQ;
			S_SQ:   if (sts.last_axis) state_n = S_SI;
			S_SI:   state_n = S_SQRT;
			S_SQRT: if (sts.sqrt_last) state_n = S_EVAL;
			S_EVAL: state_n = sts.last_idx ? S_BRD : S_RD;
			S_BRD:  state_n = S_BLD;
			S_BLD:  state_n = sts.dist_zero ? S_PZ : S_DI;
			S_PZ:   state_n = S_FIN;
			S_DI:   state_n = S_DIV;
			S_DIV:  if (sts.div_last) state_n = S_DF;
			S_DF:   state_n = sts.last_axis ? S_FIN : S_DI;
			S_FIN:  if (out_free) state_n = S_IDLE;
			default: state_n = S_IDLE;
		endcase
	end

	// command outputs
	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_IDLE: cmd.accept    = in_valid;
			S_EXEC: cmd.exec      = 1'b1;
			S_LD:   cmd.load_cur  = 1'b1;
			S_SQ:   cmd.sq_axis   = 1'b1;
			S_SI:   cmd.sqrt_init = 1'b1;
			S_SQRT: cmd.sqrt_step = 1'b1;
			S_EVAL: cmd.eval      = 1'b1;
			S_BRD:  cmd.rd_best   = 1'b1;
			S_BLD:  cmd.load_best = 1'b1;
			S_PZ:   cmd.proj_zero = 1'b1;
			S_DI:   cmd.div_init  = 1'b1;
			S_DIV:  cmd.div_step  = 1'b1;
			S_DF:   cmd.div_fin   = 1'b1;
			S_FIN:  cmd.out_load  = out_free;
			default: cmd = '0;
		endcase
	end

	// hold state and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

endmodule

// File: rtl/suq_dp.sv
// Datapath: sphere store, bounding box, distance, square root and divide units.
// Depends on suq_pkg and suq_ram; commanded by suq_ctrl.
`timescale 1ns / 1ps

module suq_dp #(
	parameter int MAX_SPHERES = suq_pkg::SUQ_MAX_SPHERES,
	parameter int NUM_DIMS    = suq_pkg::SUQ_NUM_DIMS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  suq_pkg::cmd_t        cmd,
	output suq_pkg::sts_t        sts,
	input  logic [1:0]           kind,
	input  logic signed [31:0]   pos_x,
	input  logic signed [31:0]   pos_y,
	input  logic signed [31:0]   pos_z,
	input  logic [30:0]          radius,
	output logic [1:0]           status,
	output logic                 is_inside,
	output logic signed [31:0]   proj_x,
	output logic signed [31:0]   proj_y,
	output logic signed [31:0]   proj_z,
	output logic signed [31:0]   box_min_x,
	output logic signed [31:0]   box_min_y,
	output logic signed [31:0]   box_min_z,
	output logic signed [31:0]   box_max_x,
	output logic signed [31:0]   box_max_y,
	output logic signed [31:0]   box_max_z
);
	import suq_pkg::*;

	localparam int AW = (MAX_SPHERES > 1) ? $clog2(MAX_SPHERES) : 1;
	localparam int CW = $clog2(MAX_SPHERES + 1);

	kind_t                     kind_q;
	status_t                   status_q;
	logic signed [COORD_W-1:0] p_q [3];
	logic [RAD_W-1:0]          rin_q;
	logic [CW-1:0]             count_q;
	logic signed [COORD_W-1:0] blo_q [3];
	logic signed [COORD_W-1:0] bhi_q [3];
	logic [AW-1:0]             idx_q, best_idx_q;
	logic [1:0]                axis_q;
	logic [STEP_W-1:0]         step_q;
	logic signed [COORD_W-1:0] c_q [3];
	logic [RAD_W-1:0]          rad_q;
	logic [SQ_W-1:0]           acc_q;
	logic [RADIC_W-1:0]        radic_q;
	logic [ROOT_W-1:0]         root_q;
	logic [SREM_W-1:0]         srem_q;
	logic [ROOT_W:0]           best_d_q;
	logic [ROOT_W-1:0]         best_dist_q;
	logic                      inside_q;
	logic [NUM_W-1:0]          num_q;
	logic [ROOT_W-1:0]         drem_q;
	logic                      neg_q;
	logic signed [COORD_W-1:0] proj_q [3];

	logic [1:0]                o_status_q;
	logic                      o_inside_q;
	logic signed [COORD_W-1:0] o_proj_q [3];
	logic signed [COORD_W-1:0] o_blo_q [3];
	logic signed [COORD_W-1:0] o_bhi_q [3];

	logic                      ram_we;
	logic [AW-1:0]             ram_addr;
	logic [ENTRY_W-1:0]        ram_wdata, ram_rdata;

	logic                      full, empty, inbox;
	logic signed [COORD_W-1:0] lo_n [3];
	logic signed [COORD_W-1:0] hi_n [3];
	logic signed [COORD_W:0]   dv;
	logic [COORD_W:0]          dabs;
	logic [COORD_W-1:0]        dmag;
	logic [2*COORD_W-1:0]      sq;
	logic [NUM_W-2:0]          nprod;
	logic [SREM_W+1:0]         srem_t, strial;
	logic                      sge;
	logic [ROOT_W+1:0]         ddw, ddn;
	logic [ROOT_W:0]           dd;
	logic [2*RAD_W-1:0]        rr;
	logic                      s_lt_rr;
	logic [ROOT_W:0]           drem_t;
	logic                      dge;
	logic signed [SQ_W-1:0]    qs, psum, zsum;

	assign full  = (count_q == CW'(MAX_SPHERES));
	assign empty = (count_q == '0);

	// sphere store: write at the fill count, read the walked or the best entry
	assign ram_we    = cmd.exec && kind_q == KIND_ADD && !full;
	assign ram_addr  = ram_we ? count_q[AW-1:0] : (cmd.rd_best ? best_idx_q : idx_q);
	assign ram_wdata = {rin_q, p_q[2], p_q[1], p_q[0]};

	suq_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_SPHERES)) u_store (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	// box candidates for an add and the box test for a query
	always_comb begin
		inbox = 1'b1;
		for (int d = 0; d < 3; d++) begin
			lo_n[d] = sat32($signed({{34{p_q[d][31]}}, p_q[d]} - {35'b0, rin_q}));
			hi_n[d] = sat32($signed({{34{p_q[d][31]}}, p_q[d]} + {35'b0, rin_q}));
			if (d < NUM_DIMS && (p_q[d] < blo_q[d] || bhi_q[d] < p_q[d]))
				inbox = 1'b0;
		end
	end

	// per-axis difference magnitude, square and projection numerator
	assign dv    = $signed({p_q[axis_q][31], p_q[axis_q]}) - $signed({c_q[axis_q][31], c_q[axis_q]});
	assign dabs  = dv[COORD_W] ? (~dv + 1'b1) : dv;
	assign dmag  = dabs[COORD_W-1:0];
	assign sq    = dmag * dmag;
	assign nprod = dmag * rad_q;

	// square root: one result bit per step
	assign srem_t = {srem_q, radic_q[RADIC_W-1 -: 2]};
	assign strial = {2'b0, root_q, 2'b01};
	assign sge    = (srem_t >= strial);

	// nearest-surface distance and strict inside test
	assign ddw     = {2'b0, root_q} - {7'b0, rad_q};
	assign ddn     = ~ddw + 1'b1;
	assign dd      = ddw[ROOT_W+1] ? ddn[ROOT_W:0] : ddw[ROOT_W:0];
	assign rr      = rad_q * rad_q;
	assign s_lt_rr = (acc_q < {4'b0, rr});

	// restoring divide: one quotient bit per step
	assign drem_t = {drem_q, num_q[NUM_W-1]};
	assign dge    = (drem_t >= {1'b0, best_dist_q});

	// projected coordinate of the current axis, and the along-x case
	assign qs   = neg_q ? -$signed({2'b0, num_q}) : $signed({2'b0, num_q});
	assign psum = $signed({{34{c_q[axis_q][31]}}, c_q[axis_q]}) + qs;
	assign zsum = $signed({{34{c_q[0][31]}}, c_q[0]}) + $signed({35'b0, rad_q});

	// fill count and box
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			for (int d = 0; d < 3; d++) begin
				blo_q[d] <= '0;
				bhi_q[d] <= '0;
			end
		end else if (cmd.exec && kind_q == KIND_CLEAR) begin
			count_q <= '0;
			for (int d = 0; d < 3; d++) begin
				blo_q[d] <= '0;
				bhi_q[d] <= '0;
			end
		end else if (ram_we) begin
			count_q <= count_q + 1'b1;
			for (int d = 0; d < 3; d++) begin
				if (d < NUM_DIMS) begin
					if (empty || lo_n[d] < blo_q[d]) blo_q[d] <= lo_n[d];
					if (empty || hi_n[d] > bhi_q[d]) bhi_q[d] <= hi_n[d];
				end
			end
		end
	end

	// item, walk and arithmetic registers
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			kind_q   <= kind_t'(kind);
			p_q[0]   <= pos_x;
			p_q[1]   <= pos_y;
			p_q[2]   <= pos_z;
			rin_q    <= radius;
			idx_q    <= '0;
			inside_q <= 1'b0;
			status_q <= ST_OK;
			for (int d = 0; d < 3; d++) proj_q[d] <= '0;
		end
		if (cmd.exec) begin
			if (kind_q == KIND_ADD && full)
				status_q <= ST_FULL;
			if (kind_q == KIND_QUERY && empty) begin
				status_q <= ST_EMPTY;
				for (int d = 0; d < 3; d++) proj_q[d] <= p_q[d];
			end
		end
		if (cmd.load_cur || cmd.load_best) begin
			c_q[0] <= ram_rdata[COORD_W-1:0];
			c_q[1] <= ram_rdata[2*COORD_W-1:COORD_W];
			c_q[2] <= ram_rdata[3*COORD_W-1:2*COORD_W];
			rad_q  <= ram_rdata[ENTRY_W-1:3*COORD_W];
			axis_q <= '0;
			acc_q  <= '0;
		end
		if (cmd.sq_axis) begin
			acc_q  <= acc_q + SQ_W'(sq);
			axis_q <= axis_q + 1'b1;
		end
		if (cmd.sqrt_init) begin
			radic_q <= RADIC_W'(acc_q);
			root_q  <= '0;
			srem_q  <= '0;
			step_q  <= '0;
		end
		if (cmd.sqrt_step) begin
			radic_q <= {radic_q[RADIC_W-3:0], 2'b00};
			root_q  <= {root_q[ROOT_W-2:0], sge};
			srem_q  <= sge ? SREM_W'(srem_t - strial) : SREM_W'(srem_t);
			step_q  <= step_q + 1'b1;
		end
		if (cmd.eval) begin
			if (s_lt_rr && inbox) inside_q <= 1'b1;
			if (idx_q == '0 || dd < best_d_q) begin
				best_d_q    <= dd;
				best_idx_q  <= idx_q;
				best_dist_q <= root_q;
			end
			idx_q <= idx_q + 1'b1;
		end
		if (cmd.proj_zero) begin
			proj_q[0] <= sat32(zsum);
			for (int d = 1; d < 3; d++)
				if (d < NUM_DIMS) proj_q[d] <= c_q[d];
		end
		if (cmd.div_init) begin
			neg_q  <= dv[COORD_W];
			num_q  <= NUM_W'(nprod);
			drem_q <= '0;
			step_q <= '0;
		end
		if (cmd.div_step) begin
			num_q  <= {num_q[NUM_W-2:0], dge};
			drem_q <= dge ? ROOT_W'(drem_t - {1'b0, best_dist_q}) : ROOT_W'(drem_t);
			step_q <= step_q + 1'b1;
		end
		if (cmd.div_fin) begin
			proj_q[axis_q] <= sat32(psum);
			axis_q         <= axis_q + 1'b1;
		end
		if (cmd.out_load) begin
			o_status_q <= status_q;
			o_inside_q <= inside_q;
			for (int d = 0; d < 3; d++) begin
				o_proj_q[d] <= proj_q[d];
				o_blo_q[d]  <= blo_q[d];
				o_bhi_q[d]  <= bhi_q[d];
			end
		end
	end

	assign sts.kind      = kind_q;
	assign sts.empty     = empty;
	assign sts.last_axis = (axis_q == 2'(NUM_DIMS - 1));
	assign sts.last_idx  = (CW'(idx_q) == count_q - 1'b1);
	assign sts.sqrt_last = (step_q == STEP_W'(SQRT_STEPS - 1));
	assign sts.div_last  = (step_q == STEP_W'(DIV_STEPS - 1));
	assign sts.dist_zero = (best_dist_q == '0);

	assign status    = o_status_q;
	assign is_inside = o_inside_q;
	assign proj_x    = o_proj_q[0];
	assign proj_y    = o_proj_q[1];
	assign proj_z    = o_proj_q[2];
	assign box_min_x = o_blo_q[0];
	assign box_min_y = o_blo_q[1];
	assign box_min_z = o_blo_q[2];
	assign box_max_x = o_bhi_q[0];
	assign box_max_y = o_bhi_q[1];
	assign box_max_z = o_bhi_q[2];

	// fill count never passes the store depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_SPHERES))
		else $error("sphere count above store depth");

	// box stays ordered on the first axis
	a_box_order: assert property (@(posedge clk) disable iff (!arst_n)
		blo_q[0] <= bhi_q[0])
		else $error("box lower bound above upper bound");

	// the walk only evaluates filled entries
	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.eval |-> CW'(idx_q) < count_q)
		else $error("query walk past last sphere");

	// an add to a full set leaves the count alone
	a_full_hold: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec && kind_q == KIND_ADD && full |=> count_q == $past(count_q))
		else $error("add to full set changed count");

endmodule

// File: rtl/sphere_union_query.sv
// Clear and add finish once the item is executed. A query on a non-empty set reads
// each sphere, sums its squared axis distances and takes 36 square root steps, then
// runs a 64-step divide per axis to project, unless the nearest distance is zero.
// Throughput: one item at a time; the next item is taken once the result is registered.
// Reset (arst_n low, asynchronous): the set is empty, the box is zero, no result pending.
// Depends on suq_pkg, suq_ctrl, suq_dp and suq_ram.
`timescale 1ns / 1ps

module sphere_union_query #(
	parameter int MAX_SPHERES = suq_pkg::SUQ_MAX_SPHERES,
	parameter int NUM_DIMS    = suq_pkg::SUQ_NUM_DIMS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         kind,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [31:0] pos_z,
	input  logic [30:0]        radius,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         status,
	output logic               is_inside,
	output logic signed [31:0] proj_x,
	output logic signed [31:0] proj_y,
	output logic signed [31:0] proj_z,
	output logic signed [31:0] box_min_x,
	output logic signed [31:0] box_min_y,
	output logic signed [31:0] box_min_z,
	output logic signed [31:0] box_max_x,
	output logic signed [31:0] box_max_y,
	output logic signed [31:0] box_max_z
);
	import suq_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// sequencer
	suq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// store, box and arithmetic
	suq_dp #(.MAX_SPHERES(MAX_SPHERES), .NUM_DIMS(NUM_DIMS)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.kind      (kind),
		.pos_x     (pos_x),
		.pos_y     (pos_y),
		.pos_z     (pos_z),
		.radius    (radius),
		.status    (status),
		.is_inside (is_inside),
		.proj_x    (proj_x),
		.proj_y    (proj_y),
		.proj_z    (proj_z),
		.box_min_x (box_min_x),
		.box_min_y (box_min_y),
		.box_min_z (box_min_z),
		.box_max_x (box_max_x),
		.box_max_y (box_max_y),
		.box_max_z (box_max_z)
	);

endmodule
